>>> rtl/stpr_pkg.sv
// stpr_pkg: types and constants shared by the trapezoidal stepper ramp
// holds the request and result structs, register map and reset values
// no dependencies
package stpr_pkg;

	localparam int RateW    = 16;
	localparam int IncW     = 10;
	localparam int CountW   = 16;
	localparam int ClkRateW = 32;
	localparam int DivCntW  = $clog2(ClkRateW);
	localparam int AddrW    = 4;
	localparam int DataW    = 32;

	localparam logic [RateW-1:0]    RATE_MAX       = '1;
	localparam logic [RateW-1:0]    RST_MIN_RATE   = 16'd250;
	localparam logic [IncW-1:0]     RST_RATE_INC   = 10'd10;
	localparam logic [CountW-1:0]   RST_RAMP_STEPS = 16'd975;
	localparam logic [ClkRateW-1:0] RST_CLOCK_RATE = 32'd16000000;

	localparam logic [1:0] REG_MIN_RATE   = 2'd0;
	localparam logic [1:0] REG_RATE_INC   = 2'd1;
	localparam logic [1:0] REG_RAMP_STEPS = 2'd2;
	localparam logic [1:0] REG_CLOCK_RATE = 2'd3;

	localparam logic FUNC_TICK  = 1'b0;
	localparam logic FUNC_START = 1'b1;

	typedef struct packed {
		logic              func;
		logic              direction;
		logic [CountW-1:0] step_count;
	} stpr_req_t;

	typedef struct packed {
		logic             step_pulse;
		logic             direction_out;
		logic             busy_res;
		logic [RateW-1:0] current_rate;
	} stpr_res_t;

endpackage

>>> rtl/stepper_trapezoid_ramp.sv
// stepper_trapezoid_ramp: step pulse generator with a trapezoidal speed profile
// an APB register port, a request channel of ticks and starts, a result channel
// depends on stpr_pkg
//
// Every request gives one result, registered and shown the cycle after it is taken.
// A tick that issues no step, and a start that arrives while a move is running, do
// not start the divider. A start taken while idle, and a tick that issues a step,
// load the next period as clock_rate / rate through a bit-serial restoring divider,
// one quotient bit per cycle, so the block takes no new request until the divider
// is done. Ticks between steps stream at one per cycle while the result channel is
// not stalled, and every step adds the same divider stall whatever the period is.
// Configuration must be written only idle, by the user; the block does not enforce it.
module stepper_trapezoid_ramp
	import stpr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	input  logic             in_valid,
	output logic             in_ready,
	input  stpr_req_t        in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output stpr_res_t        out_data
);

	logic [RateW-1:0]    min_rate_q;
	logic [IncW-1:0]     rate_inc_q;
	logic [CountW-1:0]   ramp_steps_q;
	logic [ClkRateW-1:0] clock_rate_q;

	logic [RateW-1:0]    rate_q;
	logic [CountW-1:0]   accel_q;
	logic [CountW-1:0]   cruise_q;
	logic [CountW-1:0]   decel_q;
	logic [ClkRateW-1:0] period_q;
	logic [ClkRateW-1:0] tick_q;
	logic                dir_q;

	logic                div_busy_q;
	logic [DivCntW-1:0]  div_cnt_q;
	logic [RateW-1:0]    div_rem_q;
	logic [RateW-1:0]    div_d_q;
	logic [ClkRateW-1:0] div_quo_q;

	logic                out_valid_q;
	stpr_res_t           out_q;

	logic                accept;
	logic                busy;
	logic [ClkRateW-1:0] tick_inc;
	logic [RateW:0]      rate_sum;
	logic [CountW:0]     two_ramp;
	logic [CountW:0]     cruise_diff;
	logic [RateW:0]      rem_shift;
	logic                rem_fits;
	logic [RateW:0]      rem_diff;

	logic [RateW-1:0]    n_rate;
	logic [CountW-1:0]   n_accel;
	logic [CountW-1:0]   n_cruise;
	logic [CountW-1:0]   n_decel;
	logic [ClkRateW-1:0] n_tick;
	logic                n_dir;
	logic                n_pulse;
	logic                div_go;
	logic [RateW-1:0]    div_src;

	assign pready    = 1'b1;
	assign accept    = in_valid && in_ready;
	assign in_ready  = !div_busy_q && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign busy      = (|accel_q) || (|cruise_q) || (|decel_q);
	assign tick_inc  = tick_q + 32'd1;
	assign rate_sum  = {1'b0, rate_q} + {{(RateW+1-IncW){1'b0}}, rate_inc_q};
	assign two_ramp  = {ramp_steps_q, 1'b0};
	assign cruise_diff = {1'b0, in_data.step_count} - two_ramp;

	// one restoring division step
	assign rem_shift = {div_rem_q, div_quo_q[ClkRateW-1]};
	assign rem_fits  = rem_shift >= {1'b0, div_d_q};
	assign rem_diff  = rem_fits ? rem_shift - {1'b0, div_d_q} : rem_shift;

	always_comb begin
		n_rate   = rate_q;
		n_accel  = accel_q;
		n_cruise = cruise_q;
		n_decel  = decel_q;
		n_tick   = tick_q;
		n_dir    = dir_q;
		n_pulse  = 1'b0;
		div_go   = 1'b0;
		div_src  = rate_q;
		if (accept) begin
			if (in_data.func == FUNC_START) begin
				if (!busy) begin
					n_dir   = in_data.direction;
					n_rate  = min_rate_q;
					n_tick  = '0;
					div_go  = 1'b1;
					div_src = min_rate_q;
					if ({1'b0, in_data.step_count} <= two_ramp) begin
						n_accel  = in_data.step_count >> 1;
						n_decel  = in_data.step_count >> 1;
						n_cruise = {{(CountW-1){1'b0}}, in_data.step_count[0]};
					end else begin
						n_accel  = ramp_steps_q;
						n_decel  = ramp_steps_q;
						n_cruise = cruise_diff[CountW-1:0];
					end
				end
			end else if (busy) begin
				n_tick = tick_inc;
				if (tick_inc >= period_q) begin
					n_tick  = '0;
					n_pulse = 1'b1;
					div_go  = 1'b1;
					if (|accel_q) begin
						n_rate  = rate_sum[RateW] ? RATE_MAX : rate_sum[RateW-1:0];
						n_accel = accel_q - 16'd1;
					end else if (|cruise_q) begin
						n_cruise = cruise_q - 16'd1;
					end else begin
						n_rate  = (rate_q > {{(RateW-IncW){1'b0}}, rate_inc_q}) ?
							rate_q - {{(RateW-IncW){1'b0}}, rate_inc_q} : '0;
						n_decel = decel_q - 16'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_rate_q   <= RST_MIN_RATE;
			rate_inc_q   <= RST_RATE_INC;
			ramp_steps_q <= RST_RAMP_STEPS;
			clock_rate_q <= RST_CLOCK_RATE;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				REG_MIN_RATE:   min_rate_q   <= pwdata[RateW-1:0];
				REG_RATE_INC:   rate_inc_q   <= pwdata[IncW-1:0];
				REG_RAMP_STEPS: ramp_steps_q <= pwdata[CountW-1:0];
				REG_CLOCK_RATE: clock_rate_q <= pwdata[ClkRateW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_MIN_RATE:   prdata = {{(DataW-RateW){1'b0}}, min_rate_q};
			REG_RATE_INC:   prdata = {{(DataW-IncW){1'b0}}, rate_inc_q};
			REG_RAMP_STEPS: prdata = {{(DataW-CountW){1'b0}}, ramp_steps_q};
			REG_CLOCK_RATE: prdata = clock_rate_q;
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q      <= '0;
			accel_q     <= '0;
			cruise_q    <= '0;
			decel_q     <= '0;
			period_q    <= '0;
			tick_q      <= '0;
			dir_q       <= 1'b1;
			div_busy_q  <= 1'b0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rate_q   <= n_rate;
			accel_q  <= n_accel;
			cruise_q <= n_cruise;
			decel_q  <= n_decel;
			tick_q   <= n_tick;
			dir_q    <= n_dir;
			if (div_go) begin
				div_busy_q <= 1'b1;
				div_cnt_q  <= '0;
			end else if (div_busy_q) begin
				div_cnt_q <= div_cnt_q + DivCntW'(1);
				if (&div_cnt_q) begin
					div_busy_q <= 1'b0;
					period_q   <= {div_quo_q[ClkRateW-2:0], rem_fits};
				end
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_go) begin
			div_rem_q <= '0;
			div_quo_q <= clock_rate_q;
			div_d_q   <= (div_src == '0) ? 16'd1 : div_src;
		end else if (div_busy_q) begin
			div_rem_q <= rem_diff[RateW-1:0];
			div_quo_q <= {div_quo_q[ClkRateW-2:0], rem_fits};
		end
		if (accept) begin
			out_q.step_pulse    <= n_pulse;
			out_q.direction_out <= n_dir;
			out_q.busy_res      <= (|n_accel) || (|n_cruise) || (|n_decel);
			out_q.current_rate  <= n_rate;
		end
	end

endmodule

>>> rtl/stpr_checker.sv
// stpr_checker: port-level assertions for the stepper ramp, bound to the top level
// watches the request and result channels only
// depends on stpr_pkg and stepper_trapezoid_ramp
module stpr_checker
	import stpr_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input stpr_req_t in_data,
	input logic      out_valid,
	input logic      out_ready,
	input stpr_res_t out_data
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// every request gives a result
	a_req_res: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("request without result");

	// no request taken over a waiting result
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request taken while result waits");

	// a start never steps
	a_start_no_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.func == FUNC_START |=> !out_data.step_pulse)
		else $error("step on start request");

endmodule

bind stepper_trapezoid_ramp stpr_checker u_stpr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
